// ----- hdl/ooksw_pkg.sv -----
// ----------------------------------------------------------------------------
// ooksw_pkg
// Types and constants shared by the OOK remote switch frame encoder.
// ----------------------------------------------------------------------------
package ooksw_pkg;

  // Width of the switch id as it arrives on the input stream
  localparam int unsigned ID_W    = 7;
  // Symbol counter width, enough for the longest frame (4 + 7 id bits and the terminator)
  localparam int unsigned SYM_W   = 6;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CADDR_W = 3;
  localparam int unsigned CDATA_W = 16;

  // Register indexes
  localparam logic [CADDR_W-1:0] CFG_REPEAT_COUNT = 3'd0;
  localparam logic [CADDR_W-1:0] CFG_SHORT_HIGH   = 3'd1;
  localparam logic [CADDR_W-1:0] CFG_LONG_HIGH    = 3'd2;
  localparam logic [CADDR_W-1:0] CFG_SHORT_LOW    = 3'd3;
  localparam logic [CADDR_W-1:0] CFG_LONG_LOW     = 3'd4;
  localparam logic [CADDR_W-1:0] CFG_SYNC_GAP     = 3'd5;

  // Register reset values
  localparam logic [7:0]        RST_REPEAT_COUNT = 8'd9;
  localparam logic [TICK_W-1:0] RST_SHORT_HIGH   = 16'd280;
  localparam logic [TICK_W-1:0] RST_LONG_HIGH    = 16'd925;
  localparam logic [TICK_W-1:0] RST_SHORT_LOW    = 16'd360;
  localparam logic [TICK_W-1:0] RST_LONG_LOW     = 16'd1000;
  localparam logic [TICK_W-1:0] RST_SYNC_GAP     = 16'd10000;

  typedef struct packed {
    logic [7:0]        repeat_count;
    logic [TICK_W-1:0] short_high;
    logic [TICK_W-1:0] long_high;
    logic [TICK_W-1:0] short_low;
    logic [TICK_W-1:0] long_low;
    logic [TICK_W-1:0] sync_gap;
  } cfg_t;

  // Position in the transmission: lead pulse flag, symbol and pulse counters
  typedef struct packed {
    logic             lead;
    logic [SYM_W-1:0] sym;
    logic [2:0]       pulse;
  } pos_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic done;
  } res_t;

endpackage

// ----- hdl/ooksw_width_sel.sv -----
// ----------------------------------------------------------------------------
// ooksw_width_sel
// Pulse width lookup: picks the tick count for a pulse from its position.
// ----------------------------------------------------------------------------
module ooksw_width_sel import ooksw_pkg::*; #(
  parameter int unsigned ID_BITS = 7
) (
  input  pos_t              pos,
  input  logic [ID_W-1:0]   held_id,
  input  logic              held_on,
  input  cfg_t              cfg,
  output logic [TICK_W-1:0] width
);

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(4 + ID_BITS);
  localparam logic [SYM_W-1:0] SYM_ID0  = SYM_W'(4);
  localparam logic [SYM_W-1:0] ID_LIM   = SYM_W'(ID_W);

  logic [SYM_W-1:0]  bit_idx;
  logic              one;
  logic [TICK_W-1:0] raw;

  assign bit_idx = pos.sym - SYM_ID0;

  always_comb begin
    if (pos.sym == '0) begin
      one = 1'b1;
    end else if (pos.sym < SYM_ID0) begin
      one = 1'b0;
    end else if (bit_idx < ID_LIM) begin
      one = held_id[bit_idx[2:0]];
    end else begin
      one = 1'b0;
    end
  end

  always_comb begin
    if (pos.lead) begin
      raw = (pos.pulse == 3'd0) ? cfg.short_high : cfg.sync_gap;
    end else if (pos.sym >= LAST_SYM) begin
      // terminator: two H or L pairs, then short high and the sync gap
      if (pos.pulse == 3'd4) begin
        raw = cfg.short_high;
      end else if (pos.pulse == 3'd5) begin
        raw = cfg.sync_gap;
      end else if (held_on) begin
        raw = pos.pulse[0] ? cfg.short_low : cfg.long_high;
      end else begin
        raw = pos.pulse[0] ? cfg.long_low : cfg.short_high;
      end
    end else begin
      case (pos.pulse)
        3'd0:    raw = cfg.short_high;
        3'd1:    raw = cfg.long_low;
        3'd2:    raw = one ? cfg.short_high : cfg.long_high;
        default: raw = one ? cfg.long_low : cfg.short_low;
      endcase
    end
  end

  // a zero width still lasts one tick
  assign width = (raw == '0) ? TICK_W'(1) : raw;

endmodule

// ----- hdl/ooksw_seq.sv -----
// ----------------------------------------------------------------------------
// ooksw_seq
// Transmission sequencer: holds the frame position and the pulse timer,
// steps on each tick and produces the per-transaction result.
// ----------------------------------------------------------------------------
module ooksw_seq import ooksw_pkg::*; #(
  parameter int unsigned ID_BITS = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            xfer,
  input  logic            cmd,
  input  logic [ID_W-1:0] switch_id,
  input  logic            switch_on,
  input  cfg_t            cfg,
  output res_t            res
);

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(4 + ID_BITS);

  logic              active_r, active_nxt;
  pos_t              pos_r, pos_nxt;
  logic [7:0]        rep_r, rep_nxt;
  logic              level_r, level_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt, ticks_dec;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              on_r, on_nxt;
  logic              load, finish;
  logic [2:0]        p1;
  logic [TICK_W-1:0] width;

  assign p1        = pos_r.pulse + 3'd1;
  assign ticks_dec = ticks_r - TICK_W'(1);

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    rep_nxt    = rep_r;
    id_nxt     = id_r;
    on_nxt     = on_r;
    load       = 1'b0;
    finish     = 1'b0;
    res        = '0;
    if (cmd) begin
      if (!active_r) begin
        id_nxt     = switch_id;
        on_nxt     = switch_on;
        rep_nxt    = cfg.repeat_count;
        active_nxt = 1'b1;
        pos_nxt    = '{lead: 1'b1, sym: '0, pulse: 3'd0};
        load       = 1'b1;
      end
      res.line_level = active_r ? level_r : 1'b1;
      res.busy       = 1'b1;
    end else if (active_r) begin
      res.line_level = level_r;
      res.busy       = 1'b1;
      if (ticks_dec == '0) begin
        if (pos_r.lead) begin
          if (p1 >= 3'd2) begin
            pos_nxt = '{lead: 1'b0, sym: '0, pulse: 3'd0};
            if (rep_r == '0) finish = 1'b1;
            else             load   = 1'b1;
          end else begin
            pos_nxt.pulse = p1;
            load          = 1'b1;
          end
        end else if (p1 >= ((pos_r.sym >= LAST_SYM) ? 3'd6 : 3'd4)) begin
          pos_nxt.pulse = 3'd0;
          if (pos_r.sym == LAST_SYM) begin
            // end of one frame repetition
            pos_nxt.sym = '0;
            rep_nxt     = rep_r - 8'd1;
            if (rep_r == 8'd1) finish = 1'b1;
            else               load   = 1'b1;
          end else begin
            pos_nxt.sym = pos_r.sym + SYM_W'(1);
            load        = 1'b1;
          end
        end else begin
          pos_nxt.pulse = p1;
          load          = 1'b1;
        end
      end
      if (finish) begin
        active_nxt = 1'b0;
        pos_nxt    = '0;
        rep_nxt    = '0;
        res.done   = 1'b1;
      end
    end
  end

  ooksw_width_sel #(
    .ID_BITS (ID_BITS)
  ) u_width (
    .pos     (pos_nxt),
    .held_id (id_nxt),
    .held_on (on_nxt),
    .cfg     (cfg),
    .width   (width)
  );

  always_comb begin
    level_nxt = level_r;
    ticks_nxt = ticks_r;
    if (load) begin
      level_nxt = ~pos_nxt.pulse[0];
      ticks_nxt = width;
    end else if (finish) begin
      level_nxt = 1'b0;
      ticks_nxt = '0;
    end else if (active_r && !cmd) begin
      ticks_nxt = ticks_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      rep_r    <= '0;
      level_r  <= 1'b0;
      ticks_r  <= '0;
      id_r     <= '0;
      on_r     <= 1'b0;
    end else if (xfer) begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      rep_r    <= rep_nxt;
      level_r  <= level_nxt;
      ticks_r  <= ticks_nxt;
      id_r     <= id_nxt;
      on_r     <= on_nxt;
    end
  end

endmodule

// ----- hdl/ook_remote_switch_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_encoder
// Tick-driven OOK waveform generator for pulse-width coded remote switches.
// ----------------------------------------------------------------------------
// Usage: each input transaction is either a tick (in_tuser = 0) or a start
// (in_tuser = 1, carrying switch id and on/off flag). A start while idle
// launches a lead pulse followed by repeat_count frames; a start while busy
// is ignored. Every input transaction yields exactly one output transaction
// carrying the line level for that tick, a busy flag and, on out_tlast, the
// end of the final sync gap.
// Result: registered, valid in the cycle after acceptance.
// Throughput: one transaction per cycle unless stalled; the state update and
// pulse width lookup sit between the sequencer state and the output register.
// Stall: the output register doubles as the buffer; in_tready is high while
// it is empty or being drained, so a held result stalls the input only for
// as long as out_tready stays low.
// Reset: synchronous, active low; the line is idle low, no output pending,
// registers back to their defaults. Write registers only while idle.
// ----------------------------------------------------------------------------
module ook_remote_switch_frame_encoder import ooksw_pkg::*; #(
  parameter int unsigned ID_BITS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [6:0] switch_id, [7] switch_on
  input  logic               in_tuser,   // [0] cmd
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [0] line_level, [1] busy_res, [7:2] zero
  output logic               out_tlast,  // done_res
  input  logic               cfg_wr_en,
  input  logic [CADDR_W-1:0] cfg_addr,
  input  logic [CDATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic xfer;

  assign in_tready = ~out_valid_r | out_tready;
  assign xfer      = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{repeat_count: RST_REPEAT_COUNT, short_high: RST_SHORT_HIGH,
                 long_high: RST_LONG_HIGH, short_low: RST_SHORT_LOW,
                 long_low: RST_LONG_LOW, sync_gap: RST_SYNC_GAP};
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_REPEAT_COUNT: cfg_r.repeat_count <= cfg_wdata[7:0];
        CFG_SHORT_HIGH:   cfg_r.short_high   <= cfg_wdata;
        CFG_LONG_HIGH:    cfg_r.long_high    <= cfg_wdata;
        CFG_SHORT_LOW:    cfg_r.short_low    <= cfg_wdata;
        CFG_LONG_LOW:     cfg_r.long_low     <= cfg_wdata;
        CFG_SYNC_GAP:     cfg_r.sync_gap     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ooksw_seq #(
    .ID_BITS (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .xfer      (xfer),
    .cmd       (in_tuser),
    .switch_id (in_tdata[ID_W-1:0]),
    .switch_on (in_tdata[7]),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.busy, res_r.line_level};
  assign out_tlast  = res_r.done;

endmodule

// ----- sim/ooksw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ooksw_checker
// Watches the encoder's streams and register port, predicts the line level,
// busy and done flags of every input transaction and compares each result.
// ----------------------------------------------------------------------------
module ooksw_checker import ooksw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,   // [6:0] switch_id, [7] switch_on
  input  logic               in_tuser,   // [0] cmd
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [7:0]         out_tdata,  // [0] line_level, [1] busy_res, [7:2] zero
  input  logic               out_tlast,  // done_res
  input  logic               cfg_wr_en,
  input  logic [CADDR_W-1:0] cfg_addr,
  input  logic [CDATA_W-1:0] cfg_wdata,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  localparam int unsigned N_ID     = 7;
  // symbol index of the terminator, after 1,0,0,0 and the id bits
  localparam logic [3:0]  TERM_SYM = 4'(4 + N_ID);

  cfg_t        regs;
  logic        tx_active;
  logic        in_lead;
  logic        level;
  logic        on_hold;
  logic [6:0]  id_hold;
  logic [7:0]  reps_left;
  logic [3:0]  sym_idx;
  logic [2:0]  pulse_idx;
  logic [15:0] ticks_left;

  res_t line_reports[$];

  initial mismatches = 0;
  initial pending = 0;

  function automatic logic [15:0] pulse_len();
    logic mark;
    if (in_lead) return (pulse_idx == 3'd0) ? regs.short_high : regs.sync_gap;
    if (sym_idx >= TERM_SYM) begin
      if (pulse_idx == 3'd4) return regs.short_high;
      if (pulse_idx == 3'd5) return regs.sync_gap;
      if (on_hold) return pulse_idx[0] ? regs.short_low : regs.long_high;
      return pulse_idx[0] ? regs.long_low : regs.short_high;
    end
    if (sym_idx == 4'd0) mark = 1'b1;
    else if (sym_idx < 4'd4) mark = 1'b0;
    else mark = id_hold[3'(sym_idx - 4'd4)];
    case (pulse_idx)
      3'd0:    return regs.short_high;
      3'd1:    return regs.long_low;
      3'd2:    return mark ? regs.short_high : regs.long_high;
      default: return mark ? regs.long_low : regs.short_low;
    endcase
  endfunction

  task automatic load_pulse();
    logic [15:0] w;
    level = ~pulse_idx[0];
    w = pulse_len();
    ticks_left = (w == 16'd0) ? 16'd1 : w;
  endtask

  task automatic go_idle();
    tx_active  = 1'b0;
    in_lead    = 1'b0;
    level      = 1'b0;
    ticks_left = '0;
    sym_idx    = '0;
    pulse_idx  = '0;
    reps_left  = '0;
  endtask

  task automatic next_pulse(output logic ended);
    ended = 1'b0;
    pulse_idx = pulse_idx + 3'd1;
    if (in_lead) begin
      if (pulse_idx >= 3'd2) begin
        in_lead   = 1'b0;
        pulse_idx = '0;
        sym_idx   = '0;
        if (reps_left == 8'd0) begin
          go_idle();
          ended = 1'b1;
        end
      end
    end else if (pulse_idx >= ((sym_idx >= TERM_SYM) ? 3'd6 : 3'd4)) begin
      pulse_idx = '0;
      sym_idx   = sym_idx + 4'd1;
      if (sym_idx > TERM_SYM) begin
        sym_idx   = '0;
        reps_left = reps_left - 8'd1;
        if (reps_left == 8'd0) begin
          go_idle();
          ended = 1'b1;
        end
      end
    end
    if (!ended) load_pulse();
  endtask

  task automatic encode_item(input logic cmd, input logic [6:0] id, input logic on,
                             output res_t r);
    logic ended;
    r = '0;
    if (cmd) begin
      // a start while busy leaves the transmission untouched
      if (!tx_active) begin
        id_hold   = id;
        on_hold   = on;
        reps_left = regs.repeat_count;
        tx_active = 1'b1;
        in_lead   = 1'b1;
        sym_idx   = '0;
        pulse_idx = '0;
        load_pulse();
      end
      r.line_level = level;
      r.busy       = 1'b1;
    end else if (tx_active) begin
      r.line_level = level;
      r.busy       = 1'b1;
      ticks_left   = ticks_left - 16'd1;
      if (ticks_left == 16'd0) begin
        next_pulse(ended);
        r.done = ended;
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs.repeat_count = RST_REPEAT_COUNT;
      regs.short_high   = RST_SHORT_HIGH;
      regs.long_high    = RST_LONG_HIGH;
      regs.short_low    = RST_SHORT_LOW;
      regs.long_low     = RST_LONG_LOW;
      regs.sync_gap     = RST_SYNC_GAP;
      go_idle();
      on_hold = 1'b0;
      id_hold = '0;
      line_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_REPEAT_COUNT: regs.repeat_count = cfg_wdata[7:0];
          CFG_SHORT_HIGH:   regs.short_high   = cfg_wdata;
          CFG_LONG_HIGH:    regs.long_high    = cfg_wdata;
          CFG_SHORT_LOW:    regs.short_low    = cfg_wdata;
          CFG_LONG_LOW:     regs.long_low     = cfg_wdata;
          CFG_SYNC_GAP:     regs.sync_gap     = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        encode_item(in_tuser, in_tdata[6:0], in_tdata[7], want);
        line_reports.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (line_reports.size() == 0) begin
          $error("result with no transaction waiting: tdata %0h, tlast %0b",
                 out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = line_reports.pop_front();
          if (out_tdata[0] !== want.line_level) begin
            $error("line_level: expected %0b, actual %0b", want.line_level, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[1] !== want.busy) begin
            $error("busy_res: expected %0b, actual %0b", want.busy, out_tdata[1]);
            mismatches++;
          end
          if (out_tlast !== want.done) begin
            $error("done_res: expected %0b, actual %0b", want.done, out_tlast);
            mismatches++;
          end
          if (out_tdata[7:2] !== 6'd0) begin
            $error("tdata padding: expected 0, actual %0h", out_tdata[7:2]);
            mismatches++;
          end
        end
      end
    end
    pending <= line_reports.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the OOK remote switch frame encoder: directed transmissions
// over edge settings, then randomised ones with ticks, ignored starts and
// stalls on both streams. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module tb_top;
  import ooksw_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tready = 1'b0;
  logic               cfg_wr_en  = 1'b0;
  logic [CADDR_W-1:0] cfg_addr   = '0;
  logic [CDATA_W-1:0] cfg_wdata  = '0;
  logic               in_tready;
  logic               out_tvalid;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  int unsigned mismatches;
  int unsigned pending;

  bit          tx_gaps    = 1'b1;
  bit          rx_gaps    = 1'b1;
  int unsigned rx_hold    = 0;
  int unsigned items_sent = 0;
  int unsigned done_seen  = 0;
  int unsigned quiet      = 0;
  logic        last_busy  = 1'b0;
  logic        last_done  = 1'b0;

  always #2 clk = ~clk;

  ook_remote_switch_frame_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ooksw_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // receiver: after each transaction, drop ready for a drawn number of cycles, possibly none
  always @(posedge clk) begin
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        w = rx_gaps ? $urandom_range(0, 9) : 0;
        if (w != 0) begin
          out_tready <= 1'b0;
          rx_hold    <= w;
        end
      end
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      last_busy <= out_tdata[1];
      last_done <= out_tlast;
      if (out_tlast) done_seen <= done_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("ook_remote_switch_frame_encoder verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // valid stays high across back-to-back transactions; only a gap or a drain lowers it
  task automatic send_item(input logic cmd, input logic [6:0] id, input logic on);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {on, id};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input cfg_t c);
    logic [CADDR_W-1:0] addrs [6];
    logic [CDATA_W-1:0] vals  [6];
    addrs = '{CFG_REPEAT_COUNT, CFG_SHORT_HIGH, CFG_LONG_HIGH,
              CFG_SHORT_LOW, CFG_LONG_LOW, CFG_SYNC_GAP};
    vals  = '{CDATA_W'(c.repeat_count), c.short_high, c.long_high,
              c.short_low, c.long_low, c.sync_gap};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    int unsigned top_w;
    top_w = ($urandom_range(0, 9) == 0) ? 12 : 3;
    c.repeat_count = 8'($urandom_range(0, 2));
    c.short_high   = 16'($urandom_range(0, top_w));
    c.long_high    = 16'($urandom_range(0, top_w));
    c.short_low    = 16'($urandom_range(0, top_w));
    c.long_low     = 16'($urandom_range(0, top_w));
    c.sync_gap     = 16'($urandom_range(0, top_w));
    return c;
  endfunction

  // One transmission: start, then ticks until the final done has come back
  // and the block reads idle. A start can slip in between the end and the
  // done being seen; that launches another transmission, which is run out.
  task automatic run_tx(input cfg_t c, input logic [6:0] id, input logic on,
                        input bit noise, input bit restart_at_once);
    int unsigned seen, ticks, bound, hi, lo;
    hi = 32'((c.short_high > c.long_high) ? c.short_high : c.long_high);
    lo = 32'((c.short_low > c.long_low) ? c.short_low : c.long_low);
    bound = (32'(c.repeat_count) + 1) * (26 * (hi + lo + 2) + hi + 32'(c.sync_gap) + 2)
            + 64;
    seen  = done_seen;
    send_item(1'b1, id, on);
    if (restart_at_once) send_item(1'b1, ~id, ~on);
    ticks = 0;
    while (ticks < bound) begin
      if (done_seen != seen) begin
        drain();
        if (!last_busy || last_done) break;
        seen  = done_seen;
        ticks = 0;
      end
      if (noise && $urandom_range(0, 99) < 3) begin
        send_item(1'b1, 7'($urandom), 1'($urandom));
      end else begin
        send_item(1'b0, 7'($urandom), 1'($urandom));
        ticks++;
      end
    end
    drain();
  endtask

  initial begin
    cfg_t        setting;
    int unsigned target;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks with nothing to send
    send_item(1'b0, 7'h7F, 1'b1);
    send_item(1'b0, 7'h00, 1'b0);
    send_item(1'b0, 7'h2A, 1'b1);
    drain();

    // all-ones id, H terminator, a start straight after the start
    setting = '{8'd1, 16'd1, 16'd2, 16'd1, 16'd2, 16'd3};
    write_regs(setting);
    run_tx(setting, 7'h7F, 1'b1, 1'b0, 1'b1);

    // zero repeat count: lead pulse only
    setting = '{8'd0, 16'd2, 16'd1, 16'd3, 16'd1, 16'd2};
    write_regs(setting);
    run_tx(setting, 7'h00, 1'b0, 1'b0, 1'b0);

    // zero-length widths last one tick each
    setting = '{8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    write_regs(setting);
    run_tx(setting, 7'h55, 1'b1, 1'b1, 1'b0);
    run_tx(setting, 7'h2A, 1'b0, 1'b1, 1'b0);

    // several repeats, then a long lead pulse; streams run flat out
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    setting = '{8'd3, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    write_regs(setting);
    run_tx(setting, 7'h4D, 1'b1, 1'b0, 1'b0);
    setting = '{8'd0, 16'd60, 16'd1, 16'd1, 16'd1, 16'd60};
    write_regs(setting);
    run_tx(setting, 7'h33, 1'b0, 1'b0, 1'b0);

    target = 1150;
    while (items_sent < target) begin
      setting = random_regs();
      write_regs(setting);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3)) send_item(1'b0, 7'($urandom), 1'($urandom));
        run_tx(setting, 7'($urandom), 1'($urandom), 1'b1, $urandom_range(0, 9) == 0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ook_remote_switch_frame_encoder verification clean");
    end else begin
      $display("ook_remote_switch_frame_encoder verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ooksw_pkg.sv
hdl/ooksw_width_sel.sv
hdl/ooksw_seq.sv
hdl/ook_remote_switch_frame_encoder.sv
sim/ooksw_checker.sv
sim/tb_top.sv
